// File: rtl/hbt_pkg.sv
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types, constants and helpers for the pipeline hazard bubble tracker.
// ----------------------------------------------------------------------------
package hbt_pkg;

  // Pipeline geometry and limits
  localparam int unsigned STAGE_COUNT = 8;
  localparam int unsigned REG_COUNT   = 32;
  localparam int unsigned MAX_FLUSH   = 15;
  localparam int unsigned REG_W       = 5;
  localparam int unsigned CNT_W       = 32;

  // Stage positions
  localparam int unsigned STG_ID   = 2;
  localparam int unsigned STG_EXE1 = 3;
  localparam int unsigned STG_WB   = 7;

  // Counter values
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CNT_W-1:0] CYCLE_RESET = CNT_W'(STAGE_COUNT - 1);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SRC   = 2'd1,
    KIND_DEST  = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_e;

  // Per-cell operation
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_CLEAR,
    CELL_LOAD
  } cell_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_BUBBLE,
    S_DONE
  } state_e;

  // One pipeline slot
  typedef struct packed {
    logic             valid;
    logic [REG_W-1:0] dest;
    logic [2:0]       rdy;
  } slot_t;

  // Control from the sequencer to the slot chain
  typedef struct packed {
    logic  tick;
    logic  bubble;
    logic  load;
    slot_t load_slot;
  } chain_ctrl_t;

  // Youngest producer match among EXE1..MEM2
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
    logic [2:0] rdy;
  } match_t;

  // Saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/hbt_if.sv
// ----------------------------------------------------------------------------
// hbt_if
// Valid/ready channels carrying input and result items of the tracker.
// ----------------------------------------------------------------------------
interface hbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] reg_num;
  logic [2:0] stage;
  logic [3:0] flush_count;

  modport source (output valid, kind, reg_num, stage, flush_count, input ready);
  modport sink   (input valid, kind, reg_num, stage, flush_count, output ready);
endinterface

interface hbt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cycle_total;
  logic [31:0] bubble_total;
  logic [31:0] flush_total;
  logic [2:0]  bubbles_added;
  logic [31:0] hazards_exe1;
  logic [31:0] hazards_exe2;
  logic [31:0] hazards_mem1;
  logic [31:0] hazards_mem2;

  modport source (output valid, cycle_total, bubble_total, flush_total, bubbles_added,
                  hazards_exe1, hazards_exe2, hazards_mem1, hazards_mem2,
                  input ready);
  modport sink   (input valid, cycle_total, bubble_total, flush_total, bubbles_added,
                  hazards_exe1, hazards_exe2, hazards_mem1, hazards_mem2,
                  output ready);
endinterface

// File: rtl/hbt_cell.sv
// ----------------------------------------------------------------------------
// hbt_cell
// One pipeline slot: holds, shifts from its neighbour, clears or loads.
// ----------------------------------------------------------------------------
module hbt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hbt_pkg::cell_op_e            op_i,
  input  hbt_pkg::slot_t               prev_i,
  input  hbt_pkg::slot_t               load_i,
  input  logic [hbt_pkg::REG_W-1:0]    src_reg_i,
  output hbt_pkg::slot_t               slot_o,
  output logic                         hit_o
);

  hbt_pkg::slot_t slot_q, slot_d;

  // Select next slot contents
  always_comb begin
    case (op_i)
      hbt_pkg::CELL_HOLD:  slot_d = slot_q;
      hbt_pkg::CELL_SHIFT: slot_d = prev_i;
      hbt_pkg::CELL_CLEAR: slot_d = '0;
      hbt_pkg::CELL_LOAD:  slot_d = load_i;
      default:             slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  // Flag a producer of the requested register
  assign hit_o  = slot_q.valid && (slot_q.dest == src_reg_i);
  assign slot_o = slot_q;

endmodule

// File: rtl/hbt_slot_chain.sv
// ----------------------------------------------------------------------------
// hbt_slot_chain
// Row of slot cells IF1..WB with shift control and youngest-first match.
// ----------------------------------------------------------------------------
module hbt_slot_chain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hbt_pkg::chain_ctrl_t         ctrl_i,
  input  logic [hbt_pkg::REG_W-1:0]    src_reg_i,
  output hbt_pkg::match_t              match_o
);

  hbt_pkg::cell_op_e ops   [hbt_pkg::STAGE_COUNT];
  hbt_pkg::slot_t    slots [hbt_pkg::STAGE_COUNT];
  hbt_pkg::slot_t    prevs [hbt_pkg::STAGE_COUNT];
  logic              hits  [hbt_pkg::STAGE_COUNT];

  // Decode per-cell operation
  always_comb begin
    for (int g = 0; g < int'(hbt_pkg::STAGE_COUNT); g++) begin
      ops[g] = hbt_pkg::CELL_HOLD;
      if (ctrl_i.tick) begin
        ops[g] = (g == 0) ? hbt_pkg::CELL_CLEAR : hbt_pkg::CELL_SHIFT;
      end else if (ctrl_i.bubble) begin
        if (g == int'(hbt_pkg::STG_EXE1)) begin
          ops[g] = hbt_pkg::CELL_CLEAR;
        end else if (g > int'(hbt_pkg::STG_EXE1)) begin
          ops[g] = hbt_pkg::CELL_SHIFT;
        end
      end else if (ctrl_i.load && (g == int'(hbt_pkg::STG_ID))) begin
        ops[g] = hbt_pkg::CELL_LOAD;
      end
    end
  end

  // Build the row of cells
  for (genvar g = 0; g < hbt_pkg::STAGE_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prevs[g] = '0;
    end else begin : g_link
      assign prevs[g] = slots[g-1];
    end

    hbt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (ops[g]),
      .prev_i    (prevs[g]),
      .load_i    (ctrl_i.load_slot),
      .src_reg_i (src_reg_i),
      .slot_o    (slots[g]),
      .hit_o     (hits[g])
    );
  end

  // Pick the youngest producer in EXE1..MEM2 (lowest stage wins)
  always_comb begin
    match_o = '0;
    for (int i = int'(hbt_pkg::STG_WB) - 1; i >= int'(hbt_pkg::STG_EXE1); i--) begin
      if (hits[i]) begin
        match_o.hit = 1'b1;
        match_o.idx = 2'(i - int'(hbt_pkg::STG_EXE1));
        match_o.rdy = slots[i].rdy;
      end
    end
  end

endmodule

// File: rtl/pipeline_hazard_bubble_tracker.sv
// ----------------------------------------------------------------------------
// pipeline_hazard_bubble_tracker
// Hazard timing scoreboard for an eight-stage in-order pipeline.
// Timing: an accepted item goes to the done state, then its result is loaded
//   into the output register; a flush or a read inserting bubbles first runs
//   its slot-chain shifts (one slot-chain shift per cycle).
// Items: no new item is taken before the last one is through; the next
//   item is taken once the result is in the output register, which may still
//   wait for the sink.
// Reset: all slots empty, counters zero, cycle count seven.
// ----------------------------------------------------------------------------
module pipeline_hazard_bubble_tracker (
  input  logic      clk_i,
  input  logic      rst_ni,
  hbt_in_if.sink    in_i,
  hbt_out_if.source out_o
);

  hbt_pkg::state_e      state_q, state_d;
  logic [3:0]           rem_q, rem_d;
  logic [2:0]           added_q, added_d;
  logic [hbt_pkg::CNT_W-1:0] cycle_q, bubble_q, flush_q;
  logic [hbt_pkg::CNT_W-1:0] haz_q [4];
  logic                 out_valid_q;

  hbt_pkg::chain_ctrl_t ctrl;
  hbt_pkg::match_t      match;
  logic                 acc, reg_ok, src_hit, out_free, out_load;
  logic                 cyc_inc, bub_inc, fl_inc, haz_inc;
  logic [4:0]           n_raw;
  logic [2:0]           n_bub;
  logic [3:0]           fl_cnt;

  // Slot chain
  hbt_slot_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .src_reg_i (in_i.reg_num),
    .match_o   (match)
  );

  // Decode the incoming item
  assign in_i.ready = (state_q == hbt_pkg::S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign reg_ok     = {2'b00, in_i.reg_num} < 7'(hbt_pkg::REG_COUNT);
  assign src_hit    = (in_i.kind == hbt_pkg::KIND_SRC) && (in_i.reg_num != '0) &&
                      reg_ok && match.hit;
  assign n_raw      = {2'b00, match.rdy} + 5'd2 - {3'b000, match.idx}
                      - 5'(hbt_pkg::STG_EXE1) - {2'b00, in_i.stage};
  assign n_bub      = n_raw[4] ? 3'd0 : n_raw[2:0];
  assign fl_cnt     = (in_i.flush_count > 4'(hbt_pkg::MAX_FLUSH)) ?
                      4'(hbt_pkg::MAX_FLUSH) : in_i.flush_count;
  assign out_free   = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    added_d = added_q;
    case (state_q)
      hbt_pkg::S_IDLE: begin
        if (acc) begin
          added_d = 3'd0;
          state_d = hbt_pkg::S_DONE;
          case (in_i.kind)
            hbt_pkg::KIND_SRC: begin
              if (src_hit) begin
                added_d = n_bub;
                if (n_bub != 3'd0) begin
                  rem_d   = {1'b0, n_bub};
                  state_d = hbt_pkg::S_BUBBLE;
                end
              end
            end
            hbt_pkg::KIND_FLUSH: begin
              if (fl_cnt != 4'd0) begin
                rem_d   = fl_cnt;
                state_d = hbt_pkg::S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      hbt_pkg::S_FLUSH, hbt_pkg::S_BUBBLE: begin
        rem_d = rem_q - 4'd1;
        if (rem_q == 4'd1) begin
          state_d = hbt_pkg::S_DONE;
        end
      end
      hbt_pkg::S_DONE: begin
        if (out_free) begin
          state_d = hbt_pkg::S_IDLE;
        end
      end
      default: state_d = hbt_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl        = '0;
    ctrl.tick   = (acc && (in_i.kind == hbt_pkg::KIND_TICK)) ||
                  (state_q == hbt_pkg::S_FLUSH);
    ctrl.bubble = (state_q == hbt_pkg::S_BUBBLE);
    ctrl.load   = acc && (in_i.kind == hbt_pkg::KIND_DEST);
    ctrl.load_slot.valid = reg_ok;
    ctrl.load_slot.dest  = reg_ok ? in_i.reg_num : '0;
    ctrl.load_slot.rdy   = in_i.stage;
    cyc_inc  = ctrl.tick || ctrl.bubble;
    bub_inc  = ctrl.bubble;
    fl_inc   = (state_q == hbt_pkg::S_FLUSH);
    haz_inc  = acc && src_hit;
    out_load = (state_q == hbt_pkg::S_DONE) && out_free;
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbt_pkg::S_IDLE;
      rem_q   <= '0;
      added_q <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      added_q <= added_d;
    end
  end

  // Saturating counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q  <= hbt_pkg::CYCLE_RESET;
      bubble_q <= '0;
      flush_q  <= '0;
      for (int h = 0; h < 4; h++) begin
        haz_q[h] <= '0;
      end
    end else begin
      if (cyc_inc) cycle_q  <= hbt_pkg::sat_inc(cycle_q);
      if (bub_inc) bubble_q <= hbt_pkg::sat_inc(bubble_q);
      if (fl_inc)  flush_q  <= hbt_pkg::sat_inc(flush_q);
      if (haz_inc) haz_q[match.idx] <= hbt_pkg::sat_inc(haz_q[match.idx]);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.cycle_total   <= cycle_q;
      out_o.bubble_total  <= bubble_q;
      out_o.flush_total   <= flush_q;
      out_o.bubbles_added <= added_q;
      out_o.hazards_exe1  <= haz_q[0];
      out_o.hazards_exe2  <= haz_q[1];
      out_o.hazards_mem1  <= haz_q[2];
      out_o.hazards_mem2  <= haz_q[3];
    end
  end

  assign out_o.valid = out_valid_q;

  // Assertions
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == hbt_pkg::S_FLUSH) || (state_q == hbt_pkg::S_BUBBLE)) |-> (rem_q != 4'd0))
    else $error("flush or bubble sequence running with no steps left");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q != hbt_pkg::S_IDLE))
    else $error("accepted item did not leave idle");

  a_cycle_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycle_q >= hbt_pkg::CYCLE_RESET)
    else $error("cycle counter fell below its start value");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == hbt_pkg::S_IDLE)))
    else $error("result load did not publish and return to idle");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipeline hazard bubble tracker. Items go in over
// the valid/ready input channel; a scoreboard model of the eight slots and the
// counters predicts every result, and each result is compared field by field
// with the oldest prediction. Directed cases come first, then dependent
// producer/consumer sequences mixed with noise, with random idling on both
// channels, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LONG_HOLD   = 60;

  // One predicted result
  typedef struct packed {
    logic [31:0] cycles;
    logic [31:0] bubbles;
    logic [31:0] flushes;
    logic [2:0]  added;
    logic [31:0] exe1;
    logic [31:0] exe2;
    logic [31:0] mem1;
    logic [31:0] mem2;
  } tally_t;

  logic clk_i;
  logic rst_ni;

  hbt_in_if  in_if ();
  hbt_out_if out_if ();

  pipeline_hazard_bubble_tracker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Scoreboard copy of the pipeline
  logic        slot_vld [STAGE_COUNT];
  logic [4:0]  slot_reg [STAGE_COUNT];
  logic [2:0]  slot_rdy [STAGE_COUNT];
  logic [31:0] haz_cnt  [4];
  logic [31:0] cycle_cnt;
  logic [31:0] bubble_cnt;
  logic [31:0] flush_cnt;

  tally_t      expected_tallies [$];
  int unsigned errors;
  int unsigned cycles_run;
  int unsigned sink_hold_req;
  bit          quiet;

  // Clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Move slots above lowest up by one and empty the lowest
  function automatic void shift_slots(int lowest);
    for (int i = STG_WB; i > lowest; i--) begin
      slot_vld[i] = slot_vld[i-1];
      slot_reg[i] = slot_reg[i-1];
      slot_rdy[i] = slot_rdy[i-1];
    end
    slot_vld[lowest] = 1'b0;
    slot_reg[lowest] = '0;
    slot_rdy[lowest] = '0;
  endfunction

  function automatic void clear_tracker();
    for (int i = 0; i < STAGE_COUNT; i++) begin
      slot_vld[i] = 1'b0;
      slot_reg[i] = '0;
      slot_rdy[i] = '0;
    end
    for (int i = 0; i < 4; i++) haz_cnt[i] = '0;
    cycle_cnt  = 32'(STAGE_COUNT - 1);
    bubble_cnt = '0;
    flush_cnt  = '0;
  endfunction

  function automatic void advance_clock();
    cycle_cnt = bump(cycle_cnt);
    shift_slots(0);
  endfunction

  function automatic void insert_bubble();
    bubble_cnt = bump(bubble_cnt);
    cycle_cnt  = bump(cycle_cnt);
    shift_slots(STG_EXE1);
  endfunction

  // Apply one accepted item and queue the result it must produce
  function automatic void predict_item(kind_e k, logic [4:0] r, logic [2:0] s,
                                       logic [3:0] f);
    tally_t      t;
    int          n;
    int unsigned steps;
    bit          matched;
    n = 0;
    matched = 1'b0;
    case (k)
      KIND_TICK: begin
        advance_clock();
      end
      KIND_SRC: begin
        if (r != 0 && r < REG_COUNT) begin
          // youngest producer in EXE1..MEM2 (lowest stage) wins
          for (int i = STG_EXE1; i < STG_WB; i++) begin
            if (!matched && slot_vld[i] && slot_reg[i] == r) begin
              matched = 1'b1;
              haz_cnt[i-STG_EXE1] = bump(haz_cnt[i-STG_EXE1]);
              n = int'(slot_rdy[i]) - i - int'(s) + 2;
              if (n < 0) n = 0;
            end
          end
          repeat (n) insert_bubble();
        end
      end
      KIND_DEST: begin
        slot_vld[STG_ID] = (r < REG_COUNT);
        slot_reg[STG_ID] = (r < REG_COUNT) ? r : '0;
        slot_rdy[STG_ID] = s;
      end
      KIND_FLUSH: begin
        steps = (f > MAX_FLUSH) ? MAX_FLUSH : f;
        repeat (steps) begin
          flush_cnt = bump(flush_cnt);
          advance_clock();
        end
      end
      default: ;
    endcase
    t.cycles  = cycle_cnt;
    t.bubbles = bubble_cnt;
    t.flushes = flush_cnt;
    t.added   = 3'(n);
    t.exe1    = haz_cnt[0];
    t.exe2    = haz_cnt[1];
    t.mem1    = haz_cnt[2];
    t.mem2    = haz_cnt[3];
    expected_tallies.push_back(t);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string what, logic [31:0] want,
                                        logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    tally_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tallies.size() == 0) begin
        $display("%0t: result with no item pending, cycle_total %0d", $time,
                 out_if.cycle_total);
        errors++;
      end else begin
        want = expected_tallies.pop_front();
        compare_field("cycle_total", want.cycles, out_if.cycle_total);
        compare_field("bubble_total", want.bubbles, out_if.bubble_total);
        compare_field("flush_total", want.flushes, out_if.flush_total);
        compare_field("bubbles_added", 32'(want.added), 32'(out_if.bubbles_added));
        compare_field("hazards_exe1", want.exe1, out_if.hazards_exe1);
        compare_field("hazards_exe2", want.exe2, out_if.hazards_exe2);
        compare_field("hazards_mem1", want.mem1, out_if.hazards_mem1);
        compare_field("hazards_mem2", want.mem2, out_if.hazards_mem2);
      end
    end
  end

  // Result sink: random stall bursts, or a long hold when one is requested
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req != 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then maybe idle for a short burst
  task automatic send_item(kind_e k, logic [4:0] r, logic [2:0] s, logic [3:0] f);
    int unsigned gap;
    in_if.valid       <= 1'b1;
    in_if.kind        <= k;
    in_if.reg_num     <= r;
    in_if.stage       <= s;
    in_if.flush_count <= f;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_item(k, r, s, f);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of every field and a hazard in each producer stage
  task automatic test_directed_cases();
    send_item(KIND_TICK, 5'd31, 3'd7, 4'd15);
    send_item(KIND_SRC, 5'd0, 3'd0, 4'd0);
    // worst case: producer ready at WB, reader needs it in IF1, six bubbles
    send_item(KIND_DEST, 5'd31, 3'd7, 4'd0);
    send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    send_item(KIND_SRC, 5'd31, 3'd0, 4'd15);
    // producer in MEM1, value already there in time
    send_item(KIND_DEST, 5'd1, 3'd0, 4'd0);
    repeat (3) send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    send_item(KIND_SRC, 5'd1, 3'd7, 4'd0);
    // producer in MEM2
    send_item(KIND_DEST, 5'd16, 3'd5, 4'd0);
    repeat (4) send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    send_item(KIND_SRC, 5'd16, 3'd0, 4'd0);
    // producer in EXE2, one bubble
    send_item(KIND_DEST, 5'd2, 3'd4, 4'd0);
    repeat (2) send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    send_item(KIND_SRC, 5'd2, 3'd1, 4'd0);
    // flush extremes and a write of register zero
    send_item(KIND_FLUSH, 5'd0, 3'd0, 4'd0);
    send_item(KIND_FLUSH, 5'd31, 3'd7, 4'd15);
    send_item(KIND_DEST, 5'd0, 3'd3, 4'd0);
    send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    send_item(KIND_SRC, 5'd0, 3'd0, 4'd0);
  endtask

  // Hold the result sink for a long stretch while items keep coming
  task automatic test_backpressure();
    sink_hold_req = LONG_HOLD;
    send_item(KIND_DEST, 5'd7, 3'd6, 4'd0);
    send_item(KIND_TICK, 5'd0, 3'd0, 4'd0);
    repeat (10) send_item(KIND_SRC, 5'd7, 3'($urandom_range(0, 7)), 4'd0);
    wait_for_results();
  endtask

  // Dependent producer/consumer sequences mixed with flushes and noise
  task automatic run_random_stream(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned hops;
    logic [4:0]  r;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = 5'($urandom_range(1, 31));
        send_item(KIND_DEST, r, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        hops = $urandom_range(0, 5);
        repeat (hops) begin
          send_item(KIND_TICK, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                    4'($urandom_range(0, 15)));
        end
        if (pick >= 50) r = 5'($urandom_range(0, 31));
        send_item(KIND_SRC, r, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        sent += hops + 2;
      end else if (pick < 70) begin
        send_item(KIND_FLUSH, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 2)));
        sent++;
      end else begin
        send_item(kind_e'($urandom_range(0, 2)), 5'($urandom_range(0, 31)),
                  3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        sent++;
      end
    end
  endtask

  // Let the tracker drain completely between two bursts
  task automatic test_drain_pause();
    run_random_stream(30);
    wait_for_results();
    run_random_stream(30);
  endtask

  // Watchdog
  initial begin : watchdog
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    errors        = 0;
    quiet         = 1'b0;
    sink_hold_req = 0;
    clear_tracker();
    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.kind        <= KIND_TICK;
    in_if.reg_num     <= '0;
    in_if.stage       <= '0;
    in_if.flush_count <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_backpressure();
    run_random_stream(600);
    test_drain_pause();
    run_random_stream(500);
    // no idling on either side from here on
    quiet = 1'b1;
    run_random_stream(250);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
